// ----- sv/assert_macros.svh -----
// Assertion macros for the tracker RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, disabled during reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion sampled on the rising clock edge, active during reset as well.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- sv/mftrk_pkg.sv -----
// Types and constants shared by the motor feedback multi-turn tracker.
`default_nettype none

package mftrk_pkg;

	localparam int ID_W    = 11;
	localparam int ANG_W   = 16;
	localparam int VAL_W   = 16;
	localparam int TEMP_W  = 8;
	localparam int WIDE_W  = 32;
	localparam int CNT_W   = 16;
	localparam int MIDX_W  = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_ID      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CALIB_FRAMES = 2'd1;

	localparam logic [ID_W-1:0]  BASE_ID_RESET      = 11'd513;
	localparam logic [CNT_W-1:0] CALIB_FRAMES_RESET = 16'd50;

	typedef struct packed {
		logic [ID_W-1:0]          frame_id;
		logic [ANG_W-1:0]         angle_raw;
		logic signed [VAL_W-1:0]  speed_raw;
		logic signed [VAL_W-1:0]  current_raw;
		logic [TEMP_W-1:0]        temperature_raw;
		logic                     reset_valid;
		logic [MIDX_W-1:0]        reset_motor;
	} in_item_t;

	typedef struct packed {
		logic [MIDX_W-1:0]        motor_index;
		logic [ANG_W-1:0]         angle;
		logic signed [VAL_W-1:0]  speed;
		logic signed [VAL_W-1:0]  current;
		logic [TEMP_W-1:0]        temperature;
		logic signed [WIDE_W-1:0] unwrapped_angle;
		logic signed [WIDE_W-1:0] round_count;
		logic [ANG_W-1:0]         zero_angle;
		logic                     calibrating;
	} out_item_t;

	typedef struct packed {
		logic [ANG_W-1:0]         angle;
		logic [ANG_W-1:0]         offset;
		logic [WIDE_W-1:0]        turns;
		logic [WIDE_W-1:0]        total;
		logic signed [VAL_W-1:0]  speed;
		logic signed [VAL_W-1:0]  current;
		logic [TEMP_W-1:0]        temperature;
		logic [CNT_W-1:0]         count;
	} rec_t;

endpackage

`default_nettype wire

// ----- sv/motor_feedback_multiturn_tracker_unit.sv -----
// Top level of the motor feedback multi-turn tracker.
// The tracker accepts one feedback frame per cycle unless a blocked result stalls the input, and
// returns its result from an output register. Each motor's record sits in a small memory with one read
// and one write port: a frame reads its record at acceptance, and the stage after acceptance updates it,
// writes it back and loads the result, with the last written record forwarded to a frame that
// follows directly on the same motor. A reset request naming another motor sets a per-motor
// mark that is folded into that motor's record at its next frame. Frames with a foreign
// identifier are accepted and dropped without a result. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module motor_feedback_multiturn_tracker_unit
	import mftrk_pkg::*;
#(
	parameter int MOTOR_COUNT = 3,
	parameter int ANGLE_BITS  = 13
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire in_item_t              in_item,
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output out_item_t                  out_item
);

	localparam int IDX_W = (MOTOR_COUNT > 1) ? $clog2(MOTOR_COUNT) : 1;

	logic [ID_W-1:0]        base_id_q;
	logic [CNT_W-1:0]       calib_frames_q;

	logic [ID_W:0]          id_diff;
	logic                   id_hit;
	logic                   accept;
	logic                   s1_go;

	logic                   valid_s1;
	in_item_t               item_s1;
	logic [IDX_W-1:0]       addr_s1;
	logic [MIDX_W-1:0]      mi_s1;

	rec_t                   ram_rd;
	rec_t                   fwd_q;
	logic [IDX_W-1:0]       fwd_addr_q;
	logic                   fwd_vld_q;
	logic [MOTOR_COUNT-1:0] mark_q;

	rec_t                   rec_raw;
	rec_t                   rec_cur;
	rec_t                   rec_nxt;
	logic                   calib;
	logic                   rm_known;
	logic [IDX_W-1:0]       rm_idx;
	logic                   self_reset;
	logic                   other_reset;

	logic                   out_valid_q;
	out_item_t              out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_id_q      <= BASE_ID_RESET;
			calib_frames_q <= CALIB_FRAMES_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BASE_ID:      base_id_q      <= cfg_data[ID_W-1:0];
				REG_CALIB_FRAMES: calib_frames_q <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign id_diff = {1'b0, in_item.frame_id} - {1'b0, base_id_q};
	assign id_hit  = !id_diff[ID_W] && (32'(id_diff[ID_W-1:0]) < MOTOR_COUNT);

	assign s1_go    = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !s1_go;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= id_hit;
		end else if (s1_go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
			addr_s1 <= id_diff[IDX_W-1:0];
			mi_s1   <= id_diff[MIDX_W-1:0];
		end
	end

	mftrk_rec_ram #(
		.DEPTH (MOTOR_COUNT),
		.IDX_W (IDX_W)
	) u_ram (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && id_hit),
		.rd_addr (id_diff[IDX_W-1:0]),
		.rd_data (ram_rd),
		.wr_en   (s1_go),
		.wr_addr (addr_s1),
		.wr_data (rec_nxt)
	);

	// The forward register always mirrors the newest contents of its entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_vld_q <= 1'b0;
		end else if (s1_go) begin
			fwd_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			fwd_q      <= rec_nxt;
			fwd_addr_q <= addr_s1;
		end
	end

	assign rec_raw = (fwd_vld_q && fwd_addr_q == addr_s1) ? fwd_q : ram_rd;

	always_comb begin
		rec_cur = rec_raw;
		if (mark_q[addr_s1]) begin
			rec_cur.offset = rec_raw.angle;
			rec_cur.turns  = '0;
			rec_cur.total  = '0;
		end
	end

	assign rm_known    = item_s1.reset_valid && (32'(item_s1.reset_motor) < MOTOR_COUNT);
	assign rm_idx      = IDX_W'(item_s1.reset_motor);
	assign self_reset  = rm_known && (rm_idx == addr_s1);
	assign other_reset = rm_known && (rm_idx != addr_s1);

	mftrk_update #(
		.ANGLE_BITS (ANGLE_BITS)
	) u_update (
		.cur          (rec_cur),
		.item         (item_s1),
		.calib_frames (calib_frames_q),
		.self_reset   (self_reset),
		.nxt          (rec_nxt),
		.calib        (calib)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mark_q <= '0;
		end else if (s1_go) begin
			mark_q[addr_s1] <= 1'b0;
			if (other_reset) begin
				mark_q[rm_idx] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			out_q.motor_index     <= mi_s1;
			out_q.angle           <= rec_nxt.angle;
			out_q.speed           <= rec_nxt.speed;
			out_q.current         <= rec_nxt.current;
			out_q.temperature     <= rec_nxt.temperature;
			out_q.unwrapped_angle <= $signed(rec_nxt.total);
			out_q.round_count     <= $signed(rec_nxt.turns);
			out_q.zero_angle      <= rec_nxt.offset;
			out_q.calibrating     <= calib;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	`ASSERT_CLK(a_mark_clear, clk, arst_n, s1_go |=> !mark_q[$past(addr_s1)], "Mark of updated motor still set after write-back.")
	`ASSERT_CLK(a_self_reset, clk, arst_n, (s1_go && self_reset) |=> (out_item.unwrapped_angle == 0 && out_item.round_count == 0), "Reset of the updated motor did not clear its total.")
	`ASSERT_CLK(a_result_loaded, clk, arst_n, s1_go |=> out_valid, "Result of a finished frame was not presented.")
	`ASSERT_ALWAYS(a_stall_cause, clk, in_stall |-> (valid_s1 && out_valid_q && out_stall), "Input stalled without a blocked result.")

endmodule

`default_nettype wire

// ----- sv/mftrk_rec_ram.sv -----
// Motor record memory: one write port, one registered read port, per-entry valid bits.
`default_nettype none

module mftrk_rec_ram
	import mftrk_pkg::*;
#(
	parameter int DEPTH = 3,
	parameter int IDX_W = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rd_en,
	input  wire logic [IDX_W-1:0] rd_addr,
	output rec_t                  rd_data,
	input  wire logic             wr_en,
	input  wire logic [IDX_W-1:0] wr_addr,
	input  wire rec_t             wr_data
);

	rec_t             mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	rec_t             rd_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= valid_q[rd_addr];
			end
		end
	end

	// An entry never written reads as the all-zero reset record.
	assign rd_data = rd_valid_q ? rd_q : '0;

endmodule

`default_nettype wire

// ----- sv/mftrk_update.sv -----
// Record update for one feedback frame: offset capture, turn counting and total angle.
`default_nettype none

module mftrk_update
	import mftrk_pkg::*;
#(
	parameter int ANGLE_BITS = 13
) (
	input  wire rec_t              cur,
	input  wire in_item_t          item,
	input  wire logic [CNT_W-1:0]  calib_frames,
	input  wire logic              self_reset,
	output rec_t                   nxt,
	output logic                   calib
);

	localparam logic signed [ANG_W+1:0] HALF_POS = (ANG_W+2)'(1) <<< (ANGLE_BITS - 1);
	localparam logic signed [ANG_W+1:0] HALF_NEG = -HALF_POS;

	logic signed [ANG_W+1:0] jump;
	logic [WIDE_W-1:0]       turns_new;

	assign calib = cur.count <= calib_frames;
	assign jump  = $signed({2'b00, item.angle_raw}) - $signed({2'b00, cur.angle});

	always_comb begin
		turns_new = cur.turns;
		if (jump > HALF_POS) begin
			turns_new = cur.turns - WIDE_W'(1);
		end else if (jump < HALF_NEG) begin
			turns_new = cur.turns + WIDE_W'(1);
		end
	end

	always_comb begin
		nxt = cur;
		if (cur.count != '1) begin
			nxt.count = cur.count + CNT_W'(1);
		end
		if (calib) begin
			nxt.angle  = item.angle_raw;
			nxt.offset = item.angle_raw;
		end else begin
			nxt.angle       = item.angle_raw;
			nxt.speed       = item.speed_raw;
			nxt.current     = item.current_raw;
			nxt.temperature = item.temperature_raw;
			nxt.turns       = turns_new;
			nxt.total       = (turns_new << ANGLE_BITS) + WIDE_W'(item.angle_raw)
				- WIDE_W'(cur.offset);
		end
		if (self_reset) begin
			nxt.offset = nxt.angle;
			nxt.turns  = '0;
			nxt.total  = '0;
		end
	end

endmodule

`default_nettype wire
